### sv/orbw_pkg.sv
// Shared types and constants for the overwriting ring buffer with writeback.
package orbw_pkg;

  localparam int CAP_RESET = 16;
  localparam int OCC_W = 5;
  localparam int CFG_W = 5;

  typedef enum logic [1:0] {
    FUNC_PUT    = 2'd0,
    FUNC_PUT_WB = 2'd1,
    FUNC_GET    = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef struct packed {
    logic [7:0]  table_number;
    logic [15:0] page_number;
    logic        dirty;
  } entry_t;

  typedef struct packed {
    logic             status;
    logic [7:0]       out_table;
    logic [15:0]      out_page;
    logic             out_dirty;
    logic             writeback;
    logic [OCC_W-1:0] occupancy;
    logic             is_full;
    logic             is_empty;
  } result_t;

endpackage

### sv/overwriting_ring_buffer_with_writeback_top.sv
// Top level of the overwriting ring buffer of page descriptors with writeback.
// One operation is accepted in every cycle: busy is always low. A command
// accepted at a clock edge is registered, worked through the pointer logic in
// the next cycle, and its result is shown with done high for one cycle after
// the following edge. The entry store is a RAM with a registered read port;
// the entry at the read pointer is fetched in the cycle before it is used,
// with a bypass for an entry written in the cycle just before. The store is
// not cleared after reset and needs no clearing pass, since only written
// entries are read. The receiver cannot hold results off. A capacity write
// empties the buffer; cfg_ready is low while a command sits in the input
// register.
module overwriting_ring_buffer_with_writeback_top import orbw_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       func,
  input  logic [7:0]       table_number,
  input  logic [15:0]      page_number,
  input  logic             dirty,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             done,
  output logic             status,
  output logic [7:0]       out_table,
  output logic [15:0]      out_page,
  output logic             out_dirty,
  output logic             writeback,
  output logic [OCC_W-1:0] occupancy,
  output logic             is_full,
  output logic             is_empty
);

  localparam int PTR_W = $clog2(DEPTH);

  logic             in_valid;
  func_t            in_func;
  entry_t           in_entry;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [PTR_W-1:0] mem_raddr;
  entry_t           mem_rdata;
  result_t          res;

  assign busy      = 1'b0;
  assign cfg_ready = !in_valid;

  always_ff @(posedge clk) begin
    in_func               <= func_t'(func);
    in_entry.table_number <= table_number;
    in_entry.page_number  <= page_number;
    in_entry.dirty        <= dirty;
    status                <= res.status;
    out_table             <= res.out_table;
    out_page              <= res.out_page;
    out_dirty             <= res.out_dirty;
    writeback             <= res.writeback;
    occupancy             <= res.occupancy;
    is_full               <= res.is_full;
    is_empty              <= res.is_empty;
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  orbw_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (in_valid),
    .op_func   (in_func),
    .op_entry  (in_entry),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  orbw_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### sv/orbw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module orbw_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/orbw_ctrl.sv
// Pointer, capacity and full-flag control with the per-operation result logic.
module orbw_ctrl import orbw_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CAP_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  input  func_t            op_func,
  input  entry_t           op_entry,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_value,
  input  entry_t           mem_rdata,
  output logic             mem_we,
  output logic [PTR_W-1:0] mem_waddr,
  output entry_t           mem_wdata,
  output logic [PTR_W-1:0] mem_raddr,
  output result_t          res
);

  localparam int RST_CAP = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

  logic [PTR_W-1:0] wp, wp_next;
  logic [PTR_W-1:0] rp, rp_next;
  logic             full, full_next;
  logic [CAP_W-1:0] cap, cap_next;
  logic [CAP_W-1:0] cap_eff;
  logic             byp_valid;
  logic [PTR_W-1:0] byp_addr;
  entry_t           byp_data;
  entry_t           head;
  logic             empty;
  logic [CAP_W-1:0] occ;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] n;
    n = CAP_W'(p) + CAP_W'(1);
    return (n >= c) ? '0 : n[PTR_W-1:0];
  endfunction

  // The RAM was read last cycle at the current read pointer; a write to that
  // same entry in the same cycle is taken from the bypass register instead.
  assign head  = (byp_valid && (byp_addr == rp)) ? byp_data : mem_rdata;
  assign empty = !full && (wp == rp);

  always_comb begin
    if (cfg_value == '0) begin
      cap_eff = CAP_W'(1);
    end else if (32'(cfg_value) > DEPTH) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = CAP_W'(cfg_value);
    end
  end

  always_comb begin
    wp_next   = wp;
    rp_next   = rp;
    full_next = full;
    cap_next  = cap;
    mem_we    = 1'b0;
    mem_waddr = wp;
    mem_wdata = op_entry;
    res       = '0;
    if (rst) begin
      wp_next   = '0;
      rp_next   = '0;
      full_next = 1'b0;
      cap_next  = CAP_W'(RST_CAP);
    end else if (cfg_we) begin
      wp_next   = '0;
      rp_next   = '0;
      full_next = 1'b0;
      cap_next  = cap_eff;
    end else if (op_valid) begin
      case (op_func)
        FUNC_PUT, FUNC_PUT_WB: begin
          if (full) begin
            if ((op_func == FUNC_PUT_WB) && head.dirty) begin
              res.writeback = 1'b1;
              res.out_table = head.table_number;
              res.out_page  = head.page_number;
              res.out_dirty = 1'b1;
            end
            rp_next = wrap_inc(rp, cap);
          end
          mem_we    = 1'b1;
          wp_next   = wrap_inc(wp, cap);
          full_next = (wp_next == rp_next);
        end
        FUNC_GET: begin
          if (empty) begin
            res.status = 1'b1;
          end else begin
            res.out_table = head.table_number;
            res.out_page  = head.page_number;
            res.out_dirty = head.dirty;
            rp_next       = wrap_inc(rp, cap);
            full_next     = 1'b0;
          end
        end
        default: begin
          wp_next   = '0;
          rp_next   = '0;
          full_next = 1'b0;
        end
      endcase
    end

    if (full_next) begin
      occ = cap;
    end else if (wp_next >= rp_next) begin
      occ = CAP_W'(wp_next) - CAP_W'(rp_next);
    end else begin
      occ = cap + CAP_W'(wp_next) - CAP_W'(rp_next);
    end
    res.occupancy = OCC_W'(occ);
    res.is_full   = full_next;
    res.is_empty  = !full_next && (wp_next == rp_next);
  end

  assign mem_raddr = rp_next;

  always_ff @(posedge clk) begin
    wp       <= wp_next;
    rp       <= rp_next;
    full     <= full_next;
    cap      <= cap_next;
    byp_addr <= mem_waddr;
    byp_data <= mem_wdata;
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= mem_we;
    end
  end

`ifndef SYNTHESIS
  a_full_ptrs_equal: assert property (@(posedge clk) disable iff (rst)
    full |-> (wp == rp))
    else $error("Full flag set while the pointers differ.");

  a_ptrs_in_range: assert property (@(posedge clk) disable iff (rst)
    (CAP_W'(wp) < cap) && (CAP_W'(rp) < cap))
    else $error("A pointer lies at or beyond the capacity in use.");

  a_put_not_empty: assert property (@(posedge clk) disable iff (rst)
    (op_valid && !cfg_we && ((op_func == FUNC_PUT) || (op_func == FUNC_PUT_WB)))
      |=> (full || (wp != rp)))
    else $error("Buffer empty right after a put.");

  a_get_clears_full: assert property (@(posedge clk) disable iff (rst)
    (op_valid && !cfg_we && (op_func == FUNC_GET)) |=> !full)
    else $error("Buffer still full after a get.");
`endif

endmodule

### sim/tb_top.sv
// Testbench for the overwriting ring buffer of page descriptors with writeback.
`timescale 1ns / 1ps

module tb_top;
  import orbw_pkg::*;

  localparam int RING_DEPTH = 16;

  typedef struct {
    func_t       op;
    entry_t      page;
    int          gap;
  } cmd_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       func = FUNC_PUT;
  logic [7:0]       table_number = '0;
  logic [15:0]      page_number = '0;
  logic             dirty = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             done;
  logic             status;
  logic [7:0]       out_table;
  logic [15:0]      out_page;
  logic             out_dirty;
  logic             writeback;
  logic [OCC_W-1:0] occupancy;
  logic             is_full;
  logic             is_empty;

  overwriting_ring_buffer_with_writeback_top #(.DEPTH(RING_DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .table_number(table_number), .page_number(page_number), .dirty(dirty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status), .out_table(out_table), .out_page(out_page),
    .out_dirty(out_dirty), .writeback(writeback), .occupancy(occupancy),
    .is_full(is_full), .is_empty(is_empty)
  );

  // Shadow copy of the ring state.
  entry_t           ring_mem [RING_DEPTH];
  int               wr_ptr = 0;
  int               rd_ptr = 0;
  bit               ring_full = 0;
  logic [CFG_W-1:0] capacity_reg = CFG_W'(CAP_RESET);

  cmd_t             pending_cmds [$];
  result_t          expected_results [$];
  cmd_t             drv_cmd;
  bit               beat_taken = 0;

  int               errors = 0;
  int               cmds_taken = 0;
  int               results_checked = 0;
  int               cfg_writes = 0;
  int               wb_count = 0;
  int               empty_gets = 0;
  int               full_count = 0;
  bit               calm_stretch = 1;
  int               stretch_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int ring_cap();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > RING_DEPTH) return RING_DEPTH;
    return int'(capacity_reg);
  endfunction

  function automatic int ring_next(int p);
    return (p + 1 >= ring_cap()) ? 0 : p + 1;
  endfunction

  function automatic result_t apply_ring_op(func_t op, entry_t page);
    result_t r;
    entry_t  old;
    int      occ;
    r = '0;
    case (op)
      FUNC_PUT, FUNC_PUT_WB: begin
        if (ring_full) begin
          old = ring_mem[rd_ptr];
          if (op == FUNC_PUT_WB && old.dirty) begin
            r.writeback = 1'b1;
            r.out_table = old.table_number;
            r.out_page  = old.page_number;
            r.out_dirty = 1'b1;
            wb_count++;
          end
          rd_ptr = ring_next(rd_ptr);
        end
        ring_mem[wr_ptr] = page;
        wr_ptr = ring_next(wr_ptr);
        ring_full = (wr_ptr == rd_ptr);
      end
      FUNC_GET: begin
        if (!ring_full && wr_ptr == rd_ptr) begin
          r.status = 1'b1;
          empty_gets++;
        end else begin
          old = ring_mem[rd_ptr];
          r.out_table = old.table_number;
          r.out_page  = old.page_number;
          r.out_dirty = old.dirty;
          rd_ptr = ring_next(rd_ptr);
          ring_full = 0;
        end
      end
      default: begin
        wr_ptr = 0;
        rd_ptr = 0;
        ring_full = 0;
      end
    endcase
    if (ring_full) occ = ring_cap();
    else if (wr_ptr >= rd_ptr) occ = wr_ptr - rd_ptr;
    else occ = ring_cap() + wr_ptr - rd_ptr;
    if (ring_full) full_count++;
    r.occupancy = occ[OCC_W-1:0];
    r.is_full   = ring_full;
    r.is_empty  = !ring_full && wr_ptr == rd_ptr;
    return r;
  endfunction

  task automatic report_error(string msg);
    errors++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Driver: a command stays on the ports until its beat is taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if (pending_cmds[0].gap > 0) begin
        pending_cmds[0].gap--;
        start <= 1'b0;
      end else begin
        drv_cmd = pending_cmds.pop_front();
        func <= drv_cmd.op;
        table_number <= drv_cmd.page.table_number;
        page_number <= drv_cmd.page.page_number;
        dirty <= drv_cmd.page.dirty;
        start <= 1'b1;
      end
    end
  end

  // Monitor: checks results, predicts on accepted beats, tracks capacity writes.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_error("result with no command outstanding");
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          check_field("status", 16'(status), 16'(want.status));
          check_field("out_table", 16'(out_table), 16'(want.out_table));
          check_field("out_page", out_page, want.out_page);
          check_field("out_dirty", 16'(out_dirty), 16'(want.out_dirty));
          check_field("writeback", 16'(writeback), 16'(want.writeback));
          check_field("occupancy", 16'(occupancy), 16'(want.occupancy));
          check_field("is_full", 16'(is_full), 16'(want.is_full));
          check_field("is_empty", 16'(is_empty), 16'(want.is_empty));
        end
      end
      beat_taken <= start && !busy;
      if (start && !busy) begin
        cmds_taken++;
        expected_results.push_back(apply_ring_op(func_t'(func),
                                                 '{table_number, page_number, dirty}));
      end
      if (cfg_valid && cfg_ready) begin
        capacity_reg = cfg_data;
        wr_ptr = 0;
        rd_ptr = 0;
        ring_full = 0;
        cfg_writes++;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (stretch_left == 0) begin
      calm_stretch = $urandom_range(0, 2) == 0;
      stretch_left = $urandom_range(5, 40);
    end
    stretch_left--;
    if (calm_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic add_cmd(func_t op, logic [7:0] tn, logic [15:0] pn, logic dt);
    cmd_t c;
    c.op = op;
    c.page = '{tn, pn, dt};
    c.gap = pick_gap();
    pending_cmds.push_back(c);
  endtask

  task automatic add_random_cmds(int n, int put_pct);
    int    r;
    func_t op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < put_pct) op = ($urandom_range(0, 1) == 0) ? FUNC_PUT : FUNC_PUT_WB;
      else if (r < 94) op = FUNC_GET;
      else op = FUNC_CLEAR;
      add_cmd(op, 8'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] value);
    int seen;
    seen = cfg_writes;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] caps [11];
    caps = '{5'd1, 5'd2, 5'd0, 5'd31, 5'd3, 5'd16, 5'd7, 5'd17, 5'd4, 5'd16, 5'd12};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset capacity.
    add_cmd(FUNC_GET, 8'h00, 16'h0000, 1'b0);
    add_cmd(FUNC_CLEAR, 8'h00, 16'h0000, 1'b0);
    add_cmd(FUNC_PUT, 8'hFF, 16'hFFFF, 1'b1);
    add_cmd(FUNC_PUT_WB, 8'h00, 16'h0000, 1'b0);
    add_cmd(FUNC_GET, 8'h00, 16'h0000, 1'b0);
    add_cmd(FUNC_GET, 8'hFF, 16'hFFFF, 1'b1);
    add_cmd(FUNC_GET, 8'h00, 16'h0000, 1'b0);
    for (int i = 0; i < RING_DEPTH; i++)
      add_cmd(FUNC_PUT_WB, 8'(8'hA0 + i), 16'(16'h5A00 + i), ~i[0]);
    add_cmd(FUNC_PUT_WB, 8'hFF, 16'hFFFF, 1'b1);
    add_cmd(FUNC_PUT_WB, 8'h00, 16'h0000, 1'b0);
    add_cmd(FUNC_PUT, 8'h55, 16'hAAAA, 1'b1);
    add_cmd(FUNC_GET, 8'h00, 16'h0000, 1'b0);
    add_cmd(FUNC_CLEAR, 8'h00, 16'h0000, 1'b0);
    wait_idle();

    foreach (caps[k]) begin
      write_capacity(caps[k]);
      add_random_cmds($urandom_range(28, 40), (k % 2 == 0) ? 70 : 45);
      wait_idle();
    end

    $display("Ran %0d commands over %0d capacity writes, %0d results checked.",
             cmds_taken, cfg_writes, results_checked);
    $display("Saw %0d writebacks, %0d gets on an empty ring, %0d full states.",
             wb_count, empty_gets, full_count);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### overwriting_ring_buffer_with_writeback_top.f
sv/orbw_pkg.sv
sv/orbw_ram.sv
sv/orbw_ctrl.sv
sv/overwriting_ring_buffer_with_writeback_top.sv
sim/tb_top.sv
